// ===== rtl/core/aed_pkg.sv =====
`default_nettype none

package aed_pkg;

   // Coordinate width of the incoming points.
   localparam int COORD_BITS = 16;
   // Squared magnitude of one coordinate difference.
   localparam int SQ_BITS    = 2 * COORD_BITS;
   // Sum of three squares.
   localparam int DIST_BITS  = SQ_BITS + 2;
   localparam int ROOT_BITS  = DIST_BITS / 2;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int ROOT_STEPS = ROOT_BITS;
   localparam int STEP_BITS  = $clog2(ROOT_STEPS);
   localparam int OUT_BITS   = 17;
   localparam int NUM_EXT    = 6;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_DIFF,
      ST_MUL,
      ST_ACC,
      ST_BEST,
      ST_RINIT,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     take;
      logic     clear_sums;
      logic     diff_load;
      logic     mul_load;
      logic     acc_load;
      logic     best_load;
      logic     root_init;
      logic     root_step;
      logic     out_load;
      axis_type pair_sel;
      axis_type coord_sel;
   } cmd_type;

   function automatic coord_type coord_of(input point_type p, input axis_type a);
      coord_type c;
      unique case (a)
         AXIS_X:  c = p.x;
         AXIS_Y:  c = p.y;
         default: c = p.z;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aed_req_if.sv =====
`default_nettype none

interface aed_req_if;
   logic                  valid;
   logic                  ready;
   aed_pkg::coord_type    point_x;
   aed_pkg::coord_type    point_y;
   aed_pkg::coord_type    point_z;
   logic                  last_point;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output last_point, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   input last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aed_rsp_if.sv =====
`default_nettype none

interface aed_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [aed_pkg::OUT_BITS-1:0]  longest_length;

   modport source (output valid, output longest_length, input ready);
   modport sink   (input valid, input longest_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aed_datapath.sv =====
`default_nettype none

module aed_datapath (
   input  wire                           clock,
   input  wire                           reset,
   input  aed_pkg::cmd_type              cmd,
   input  aed_pkg::point_type            point,
   input  wire                           last_point,
   output logic [aed_pkg::OUT_BITS-1:0]  longest_length
);
   import aed_pkg::*;

   point_type                ext_ff [NUM_EXT];
   point_type                ext_in [NUM_EXT];
   logic                     seen_ff, seen_in;
   logic [COORD_BITS-1:0]    absd_ff, absd_in;
   logic [SQ_BITS-1:0]       sq_ff, sq_in;
   logic [DIST_BITS-1:0]     acc_ff, acc_in;
   logic [DIST_BITS-1:0]     best_ff, best_in;
   logic [DIST_BITS-1:0]     rad_ff, rad_in;
   logic [REM_BITS-1:0]      rem_ff, rem_in;
   logic [ROOT_BITS-1:0]     root_ff, root_in;
   logic [OUT_BITS-1:0]      out_ff, out_in;

   point_type                hi_pt, lo_pt;
   coord_type                hi_c, lo_c;
   logic signed [COORD_BITS:0] diff;
   logic signed [COORD_BITS:0] mag;
   logic [REM_BITS-1:0]      rem_sh, trial;

   // Extreme point tracking: strict compares keep the earliest point on a tie.
   always_comb begin
      for (int i = 0; i < NUM_EXT; i++) begin
         ext_in[i] = ext_ff[i];
      end
      seen_in = seen_ff;
      if (cmd.take) begin
         for (int a = 0; a < 3; a++) begin
            if (!seen_ff || coord_of(point, 2'(a)) < coord_of(ext_ff[2*a], 2'(a))) begin
               ext_in[2*a] = point;
            end
            if (!seen_ff || coord_of(point, 2'(a)) > coord_of(ext_ff[2*a+1], 2'(a))) begin
               ext_in[2*a+1] = point;
            end
         end
         seen_in = !last_point;
      end
   end

   // Pair and coordinate selection for the distance sequence.
   always_comb begin
      unique case (cmd.pair_sel)
         AXIS_X: begin
            hi_pt = ext_ff[1];
            lo_pt = ext_ff[0];
         end
         AXIS_Y: begin
            hi_pt = ext_ff[3];
            lo_pt = ext_ff[2];
         end
         default: begin
            hi_pt = ext_ff[5];
            lo_pt = ext_ff[4];
         end
      endcase
      hi_c    = coord_of(hi_pt, cmd.coord_sel);
      lo_c    = coord_of(lo_pt, cmd.coord_sel);
      diff    = {hi_c[COORD_BITS-1], hi_c} - {lo_c[COORD_BITS-1], lo_c};
      mag     = diff[COORD_BITS] ? -diff : diff;
      absd_in = mag[COORD_BITS-1:0];
   end

   assign sq_in  = absd_ff * absd_ff;
   assign acc_in = cmd.clear_sums ? '0 : acc_ff + DIST_BITS'(sq_ff);

   always_comb begin
      best_in = best_ff;
      if (cmd.clear_sums) begin
         best_in = '0;
      end else if (acc_ff > best_ff) begin
         best_in = acc_ff;
      end
   end

   // Restoring square root, one result bit per step.
   always_comb begin
      rem_sh  = {rem_ff[REM_BITS-3:0], rad_ff[DIST_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.root_init) begin
         rad_in  = best_ff;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
      end
   end

   assign out_in = OUT_BITS'(root_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_EXT; i++) begin
            ext_ff[i] <= '0;
         end
         seen_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_EXT; i++) begin
            ext_ff[i] <= ext_in[i];
         end
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         absd_ff <= absd_in;
      end
      if (cmd.mul_load) begin
         sq_ff <= sq_in;
      end
      if (cmd.acc_load || cmd.clear_sums || cmd.best_load) begin
         acc_ff <= cmd.best_load ? '0 : acc_in;
      end
      if (cmd.best_load || cmd.clear_sums) begin
         best_ff <= best_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign longest_length = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/aed_controller.sv =====
`default_nettype none

module aed_controller (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_last,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output aed_pkg::cmd_type  cmd
);
   import aed_pkg::*;

   state_type             state_ff, state_in;
   axis_type              pair_ff, pair_in;
   axis_type              coord_ff, coord_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         pair_ff      <= AXIS_X;
         coord_ff     <= AXIS_X;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pair_ff      <= pair_in;
         coord_ff     <= coord_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pair_in       = pair_ff;
      coord_in      = coord_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.pair_sel  = pair_ff;
      cmd.coord_sel = coord_ff;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_COLLECT: begin
            // No point is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.take = 1'b1;
               if (req_last) begin
                  cmd.clear_sums = 1'b1;
                  pair_in        = AXIS_X;
                  coord_in       = AXIS_X;
                  state_in       = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_load = 1'b1;
            if (coord_ff == AXIS_Z) begin
               state_in = ST_BEST;
            end else begin
               coord_in = coord_ff + 2'd1;
               state_in = ST_DIFF;
            end
         end
         ST_BEST: begin
            cmd.best_load = 1'b1;
            coord_in      = AXIS_X;
            if (pair_ff == AXIS_Z) begin
               state_in = ST_RINIT;
            end else begin
               pair_in  = pair_ff + 2'd1;
               state_in = ST_DIFF;
            end
         end
         ST_RINIT: begin
            cmd.root_init = 1'b1;
            step_in       = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == STEP_BITS'(ROOT_STEPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/axis_extreme_diameter_unit.sv =====
// Flow: a point without the last flag is absorbed in the cycle it is accepted.
// A last point starts a sequence (nine passes through the difference, square and add
// states on one shared multiplier, three max steps, root setup, 17 root steps), then the
// result is registered once the output register is free.
// Throughput: one point per cycle while collecting; the next cloud waits for the sequence.
// Reset: synchronous, active high; clears the extreme points, the cloud flag and the FSM.
`default_nettype none

module axis_extreme_diameter_unit (
   input  wire        clock,
   input  wire        reset,
   aed_req_if.sink    req_chan,
   aed_rsp_if.source  rsp_chan
);
   import aed_pkg::*;

   cmd_type    cmd;
   point_type  point;

   // Points are taken only while the controller collects. The result sits in an
   // output register, so the next cloud may stream in while the previous result
   // transaction is still pending; a second result waits for that register.
   assign point.x = req_chan.point_x;
   assign point.y = req_chan.point_y;
   assign point.z = req_chan.point_z;

   // The controller sequences the distance and root passes over the datapath.
   aed_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_point),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // The datapath holds the six extreme points, the single multiplier and the
   // bit-serial square root.
   aed_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .point          (point),
      .last_point     (req_chan.last_point),
      .longest_length (rsp_chan.longest_length)
   );

endmodule

`default_nettype wire
